// ----- src/sgm_pkg.sv -----
package sgm_pkg;

	localparam int EXP_W = 34;
	localparam int EXP_N = 200;
	localparam int MIX_W = 32;
	localparam int SQRT_N = 101;
	localparam int DIV_N = 9;
	localparam int DEC_W = 27;

	localparam logic [63:0] LN10_Q40 = 64'd12658595418;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	// floor(N/125000) is done as floor(floor(N/8)/15625).
	localparam logic [31:0] DIV125_M = 32'd2251799813;
	localparam logic [13:0] DIV125_D = 14'd15625;
	localparam logic [16:0] ROUND_125 = 17'd62500;

	// Volume decade split: u = v + 1600, decade index = u/200, taken as
	// (u * 1311) >> 18, which is exact over the whole range of u.
	localparam logic [10:0] VOL_OFFSET = 11'd1600;
	localparam logic [10:0] DIV200_M = 11'd1311;
	localparam logic [7:0] DECADE_STEP = 8'd200;
	localparam logic [3:0] UNITY_IDX = 4'd8;

	typedef logic [EXP_N-1:0][EXP_W-1:0] exp_tab_t;
	typedef logic [SQRT_N-1:0][MIX_W-1:0] sqrt_tab_t;
	typedef logic [DIV_N-1:0][DEC_W-1:0] dec_tab_t;
	typedef logic [DIV_N-1:0][31:0] rcp_tab_t;

	// Shift-and-subtract quotient, used only while the tables are built.
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = 64'd0;
		rem = 65'd0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= 65'(den)) begin
				rem = rem - 65'(den);
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		for (int r = 0; r < EXP_N; r++) begin
			x = (64'(r) * LN10_Q40 + 64'd512) >> 10;
			term = ONE_Q30;
			sum = ONE_Q30;
			for (int n = 1; n <= 30; n++) begin
				term = udiv64((term * x) >> 30, 64'(n));
				sum = sum + term;
			end
			tab[r] = sum[EXP_W-1:0];
		end
		return tab;
	endfunction

	function automatic logic [31:0] isqrt64(logic [63:0] n);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bitv;
		rem = n;
		res = 64'd0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res[31:0];
	endfunction

	function automatic sqrt_tab_t build_sqrt_tab();
		sqrt_tab_t tab;
		for (int a = 0; a < SQRT_N; a++) begin
			tab[a] = isqrt64(64'(100 * (200 - a)) << 48);
		end
		return tab;
	endfunction

	function automatic dec_tab_t build_dec_tab();
		dec_tab_t tab;
		logic [63:0] d;
		d = 64'd1;
		for (int k = 0; k < DIV_N; k++) begin
			tab[k] = d[DEC_W-1:0];
			d = d * 64'd10;
		end
		return tab;
	endfunction

	function automatic rcp_tab_t build_rcp_tab();
		rcp_tab_t tab;
		logic [63:0] d;
		logic [63:0] m;
		d = 64'd1;
		for (int k = 0; k < DIV_N; k++) begin
			m = (k == 0) ? 64'd0 : udiv64(64'h1_0000_0000, d);
			tab[k] = m[31:0];
			d = d * 64'd10;
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();
	localparam sqrt_tab_t SQRT_TAB = build_sqrt_tab();
	localparam dec_tab_t DEC_TAB = build_dec_tab();
	localparam rcp_tab_t RCP_TAB = build_rcp_tab();

endpackage

// ----- src/stereo_gain_matrix_setup_top.sv -----
// Stereo gain matrix setup: one beat in, one beat of four gains out.
// Throughput is one beat per cycle; the twelve pipeline stages each stall
// only when the stage after them is full and stalled.
// Reset (arst_n low) clears all stage valid bits; the data path is not reset.
module stereo_gain_matrix_setup_top #(
	parameter int GAIN_FRAC_BITS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// volume_tenth_db [11:0], pan_percent [19:12], width_percent [27:20],
	// position_percent [35:28], zero pad [39:36]
	input  logic [39:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// gain_left_to_left [31:0], gain_right_to_left [63:32],
	// gain_left_to_right [95:64], gain_right_to_right [127:96]
	output logic [127:0] m_tdata
);

	// Stage k loads when it is empty or when stage k+1 loads too, so a
	// stalled output beat holds only the stages that are actually full.
	logic [13:1] ld;
	logic [12:1] vld_q;

	always_comb begin
		ld[13] = m_tready;
		for (int k = 12; k >= 1; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= 12; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = ld[1];
	assign m_tvalid = vld_q[12];

	// Stage 1: saturate every input field to its legal range.
	logic signed [11:0] vol_in, vol_s1;
	logic signed [7:0] pan_in, wid_in, pos_in;
	logic signed [7:0] pan_s1, wid_s1, pos_s1;

	function automatic logic signed [7:0] clamp_pct(logic signed [7:0] v);
		if (v > 8'sd100) begin
			return 8'sd100;
		end else if (v < -8'sd100) begin
			return -8'sd100;
		end
		return v;
	endfunction

	assign vol_in = s_tdata[11:0];
	assign pan_in = s_tdata[19:12];
	assign wid_in = s_tdata[27:20];
	assign pos_in = s_tdata[35:28];

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			if (vol_in > 12'sd240) begin
				vol_s1 <= 12'sd240;
			end else if (vol_in < -12'sd1440) begin
				vol_s1 <= -12'sd1440;
			end else begin
				vol_s1 <= vol_in;
			end
			pan_s1 <= clamp_pct(pan_in);
			wid_s1 <= clamp_pct(wid_in);
			pos_s1 <= clamp_pct(pos_in);
		end
	end

	// Stage 2: split the volume into a decade index and a remainder, look up
	// the mid/side level and form the mixes and the four position-pan products.
	logic [10:0] u;
	logic [21:0] u_scaled;
	logic [3:0] cc;
	logic [7:0] r;
	logic [6:0] aw;
	logic [sgm_pkg::MIX_W-1:0] h;
	logic signed [33:0] ws, a_sum, b_sum;
	logic signed [8:0] pl9, pr9, ql9, qr9;
	logic [7:0] pl, pr, ql, qr;

	logic [3:0] cc_s2;
	logic [7:0] r_s2;
	logic [sgm_pkg::MIX_W-1:0] mix_a_s2, mix_b_s2;
	logic [3:0][15:0] qp_s2;

	always_comb begin
		u = 11'(12'(vol_s1) + 12'(sgm_pkg::VOL_OFFSET));
		u_scaled = 22'(u) * 22'(sgm_pkg::DIV200_M);
		cc = u_scaled[21:18];
		r = 8'(u - 11'(cc) * 11'(sgm_pkg::DECADE_STEP));
		aw = (wid_s1 < 0) ? 7'(-wid_s1) : 7'(wid_s1);
		h = sgm_pkg::SQRT_TAB[aw];
		ws = 34'(wid_s1) <<< 24;
		a_sum = $signed({2'b00, h}) + ws;
		b_sum = $signed({2'b00, h}) - ws;
		pl9 = 9'sd100 - 9'(pan_s1);
		pr9 = 9'sd100 + 9'(pan_s1);
		ql9 = 9'sd100 - 9'(pos_s1);
		qr9 = 9'sd100 + 9'(pos_s1);
		pl = pl9[7:0];
		pr = pr9[7:0];
		ql = ql9[7:0];
		qr = qr9[7:0];
	end

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			cc_s2 <= cc;
			r_s2 <= r;
			mix_a_s2 <= a_sum[33] ? '0 : a_sum[31:0];
			mix_b_s2 <= b_sum[33] ? '0 : b_sum[31:0];
			qp_s2[0] <= 16'(ql) * 16'(pl);
			qp_s2[1] <= 16'(ql) * 16'(pr);
			qp_s2[2] <= 16'(qr) * 16'(pl);
			qp_s2[3] <= 16'(qr) * 16'(pr);
		end
	end

	// The volume mantissa 10^(r/200) in Q30, shared by all four lanes.
	logic [sgm_pkg::EXP_W-1:0] e;
	assign e = sgm_pkg::EXP_TAB[r_s2];

	logic [3:0][31:0] gain;
	logic [3:0][sgm_pkg::MIX_W-1:0] lane_mix;

	// Left-to-left and right-to-right use the sum mix; the cross terms the
	// difference mix.
	assign lane_mix[0] = mix_a_s2;
	assign lane_mix[1] = mix_b_s2;
	assign lane_mix[2] = mix_b_s2;
	assign lane_mix[3] = mix_a_s2;

	for (genvar i = 0; i < 4; i++) begin : g_lane
		sgm_gain_lane #(
			.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
		) u_lane (
			.clk  (clk),
			.ld   (ld[12:3]),
			.mix  (lane_mix[i]),
			.qp   (qp_s2[i]),
			.e    (e),
			.cc   (cc_s2),
			.gain (gain[i])
		);
	end

	assign m_tdata = {gain[3], gain[2], gain[1], gain[0]};

endmodule

// ----- src/sgm_gain_lane.sv -----
// One matrix gain: mix * position * pan / 125000, times the volume mantissa,
// then scaled up or down by the volume decade. Stages 3 through 12 of the pipeline.
module sgm_gain_lane #(
	parameter int GAIN_FRAC_BITS = 24
) (
	input  logic                         clk,
	input  logic [12:3]                  ld,
	input  logic [sgm_pkg::MIX_W-1:0]    mix,
	input  logic [15:0]                  qp,
	input  logic [sgm_pkg::EXP_W-1:0]    e,
	input  logic [3:0]                   cc,
	output logic [31:0]                  gain
);

	localparam int SH = 57 - GAIN_FRAC_BITS;

	logic [44:0] n_s3, n_s4, n_s5, n_s6;
	logic [sgm_pkg::EXP_W-1:0] e_s3, e_s4, e_s5, e_s6, e_s7;
	logic [3:0] cc_s3, cc_s4, cc_s5, cc_s6, cc_s7, cc_s8;
	logic [54:0] ph_s4;
	logic [53:0] pl_s4;
	logic [31:0] q0_s5, q0_s6;
	logic [45:0] qm_s6;
	logic [31:0] g_s7;
	logic [48:0] ph2_s8, pl2_s8;
	logic [31:0] val_s9, val_s10, val_s11;
	logic [3:0] k_s9, k_s10, k_s11;
	logic c1_s9, c1_s10, c1_s11;
	logic [63:0] mm_s10;
	logic [58:0] qd_s11;
	logic [31:0] q0_s11;
	logic [31:0] gain_s12;

	logic [47:0] nsum;
	logic [76:0] qsum;
	logic ge;
	logic [63:0] prod, v5;
	logic [3:0] kk;
	logic [sgm_pkg::DEC_W-1:0] d9, d12;
	logic [69:0] n2w;
	logic [31:0] n2, t1;
	logic [31:0] q12, res;

	assign nsum = 48'(mix) * 48'(qp) + 48'(sgm_pkg::ROUND_125);

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			n_s3 <= nsum[47:3];
			e_s3 <= e;
			cc_s3 <= cc;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			ph_s4 <= 55'(n_s3[44:22]) * 55'(sgm_pkg::DIV125_M);
			pl_s4 <= 54'(n_s3[21:0]) * 54'(sgm_pkg::DIV125_M);
			n_s4 <= n_s3;
			e_s4 <= e_s3;
			cc_s4 <= cc_s3;
		end
	end

	assign qsum = (77'(ph_s4) << 22) + 77'(pl_s4);

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			q0_s5 <= qsum[76:45];
			n_s5 <= n_s4;
			e_s5 <= e_s4;
			cc_s5 <= cc_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			qm_s6 <= 46'(q0_s5) * 46'(sgm_pkg::DIV125_D);
			q0_s6 <= q0_s5;
			n_s6 <= n_s5;
			e_s6 <= e_s5;
			cc_s6 <= cc_s5;
		end
	end

	// The reciprocal estimate is at most one low; one compare fixes it.
	assign ge = 47'(n_s6) >= 47'(qm_s6) + 47'(sgm_pkg::DIV125_D);

	always_ff @(posedge clk) begin
		if (ld[7]) begin
			g_s7 <= q0_s6 + 32'(ge);
			e_s7 <= e_s6;
			cc_s7 <= cc_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[8]) begin
			ph2_s8 <= 49'(g_s7) * 49'(e_s7[33:17]);
			pl2_s8 <= 49'(g_s7) * 49'(e_s7[16:0]);
			cc_s8 <= cc_s7;
		end
	end

	// Both rounding steps of the decade path fold into one floor division.
	always_comb begin
		prod = 64'((66'(ph2_s8) << 17) + 66'(pl2_s8));
		v5 = (prod << 2) + prod + (64'd1 << (SH - 1));
		t1 = 32'(v5 >> SH);
		kk = (cc_s8 >= sgm_pkg::UNITY_IDX) ? 4'd0 : (sgm_pkg::UNITY_IDX - cc_s8);
		d9 = sgm_pkg::DEC_TAB[kk];
		n2w = 70'(prod) + 70'(d9 >> 1) + (70'(d9) << SH);
		n2 = 32'(n2w >> (SH + 1));
	end

	always_ff @(posedge clk) begin
		if (ld[9]) begin
			c1_s9 <= cc_s8 > sgm_pkg::UNITY_IDX;
			val_s9 <= (cc_s8 > sgm_pkg::UNITY_IDX) ? t1 : n2;
			k_s9 <= kk;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[10]) begin
			mm_s10 <= 64'(val_s9) * 64'(sgm_pkg::RCP_TAB[k_s9]);
			val_s10 <= val_s9;
			k_s10 <= k_s9;
			c1_s10 <= c1_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[11]) begin
			qd_s11 <= 59'(mm_s10[63:32]) * 59'(sgm_pkg::DEC_TAB[k_s10]);
			q0_s11 <= mm_s10[63:32];
			val_s11 <= val_s10;
			k_s11 <= k_s10;
			c1_s11 <= c1_s10;
		end
	end

	always_comb begin
		d12 = sgm_pkg::DEC_TAB[k_s11];
		q12 = q0_s11 + 32'(60'(val_s11) >= 60'(qd_s11) + 60'(d12));
		res = (c1_s11 || k_s11 == 4'd0) ? val_s11 : q12;
		if (res[31]) begin
			res = 32'h7FFF_FFFF;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[12]) begin
			gain_s12 <= res;
		end
	end

	assign gain = gain_s12;

endmodule
